FILE: rtl/fim_pkg.sv
// Package for the frame interval meter: request and result types, command
// codes, controller states and the commands and status between controller and datapath.
// No dependencies.
package fim_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_RESET = 2'd3
  } fim_cmd_t;

  localparam int TS_W   = 48;
  localparam int IV_W   = 32;
  localparam int RATE_W = 16;
  localparam int WT_W   = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_INTERVAL    = 1'd1;

  localparam logic [IV_W-1:0] TPS_RESET  = 32'd10000000;
  localparam logic [IV_W-1:0] LOCK_RESET = 32'd0;

  typedef struct packed {
    fim_cmd_t        command;
    logic [TS_W-1:0] timestamp;
  } fim_in_t;

  typedef struct packed {
    logic [IV_W-1:0]   average_ticks;
    logic [RATE_W-1:0] frame_rate;
    logic [TS_W-1:0]   total_ticks;
    logic              is_stopped;
    logic              waiting;
  } fim_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_PUSH,
    ST_DIV_START,
    ST_DIV,
    ST_PAUSE,
    ST_ELAPSED,
    ST_OUT
  } fim_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic check;
    logic push;
    logic div_start;
    logic div_run;
    logic pause;
    logic elapsed;
    logic out_load;
  } fim_ctl_t;

  typedef struct packed {
    fim_cmd_t cmd;
    logic     stopped;
    logic     wait_hit;
    logic     count_zero;
    logic     div_done;
  } fim_sts_t;

endpackage

FILE: rtl/fim_ctrl.sv
// Controller state machine for the frame interval meter.
// Depends on fim_pkg; drives the datapath commands and both handshakes.
module fim_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fim_pkg::fim_sts_t sts,
  output fim_pkg::fim_ctl_t ctl
);
  import fim_pkg::*;

  fim_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.cmd)
          CMD_TICK:  state_nxt = sts.stopped ? ST_ELAPSED : ST_CHECK;
          CMD_START: state_nxt = ST_PAUSE;
          default:   state_nxt = ST_ELAPSED;
        endcase
      end
      ST_CHECK:     state_nxt = sts.wait_hit ? ST_ELAPSED : ST_PUSH;
      ST_PUSH:      state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = sts.count_zero ? ST_ELAPSED : ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_ELAPSED;
      end
      ST_PAUSE:     state_nxt = ST_ELAPSED;
      ST_ELAPSED:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.load      = (state_r == ST_IDLE) && in_valid;
    ctl.exec      = (state_r == ST_EXEC);
    ctl.check     = (state_r == ST_CHECK);
    ctl.push      = (state_r == ST_PUSH);
    ctl.div_start = (state_r == ST_DIV_START);
    ctl.div_run   = (state_r == ST_DIV);
    ctl.pause     = (state_r == ST_PAUSE);
    ctl.elapsed   = (state_r == ST_ELAPSED);
    ctl.out_load  = (state_r == ST_OUT) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (ctl.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/fim_datapath.sv
// Datapath for the frame interval meter: timer state, interval history memory,
// running sum, bit-serial divider, configuration and result registers. Depends on fim_pkg.
module fim_datapath #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fim_pkg::fim_in_t                   in_req,
  input  logic                               cfg_valid,
  input  logic [fim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fim_pkg::IV_W-1:0]           cfg_data,
  input  fim_pkg::fim_ctl_t                  ctl,
  output fim_pkg::fim_sts_t                  sts,
  output fim_pkg::fim_out_t                  out_rsp
);
  import fim_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = IV_W + $clog2(HISTORY_DEPTH);
  localparam int REM_W = CNT_W + 1;
  localparam int DC_W  = $clog2(SUM_W + 1);

  logic [IV_W-1:0]   tps_r, lock_r;
  fim_cmd_t          cmd_r;
  logic [TS_W-1:0]   ts_r, tmp_r, elapsed_r;
  logic [TS_W-1:0]   last_r, current_r, base_r, stop_r, paused_r;
  logic              stopped_r, waiting_r, push_r;
  logic [IV_W-1:0]   iv_r, prev_avg_r, rd_data_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [RATE_W-1:0] frames_r, rate_r;
  logic [WT_W-1:0]   wticks_r;
  logic [SUM_W-1:0]  quot_r;
  logic [REM_W-1:0]  rem_r;
  logic [DC_W-1:0]   div_cnt_r;
  fim_out_t          out_r;

  logic [IV_W-1:0]   hist_mem [HISTORY_DEPTH];

  logic [IV_W-1:0]   iv;
  logic              wait_hit;
  logic [IV_W-1:0]   diff;
  logic [WT_W-1:0]   wt_sum;
  logic [RATE_W-1:0] frames_inc;
  logic              full;
  logic [SUM_W-1:0]  sum_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [TS_W-1:0]   ref_stamp;
  logic [TS_W-1:0]   total;

  assign iv       = (|tmp_r[TS_W-1:IV_W]) ? '1 : tmp_r[IV_W-1:0];
  assign wait_hit = (lock_r != '0) && (iv < lock_r);
  assign diff     = (iv >= prev_avg_r) ? (iv - prev_avg_r) : (prev_avg_r - iv);
  assign wt_sum   = wticks_r + WT_W'(iv);
  assign frames_inc = (frames_r != '1) ? (frames_r + RATE_W'(1)) : frames_r;
  assign full     = (count_r == CNT_W'(HISTORY_DEPTH));
  assign sum_nxt  = sum_r + SUM_W'(iv_r) - (full ? SUM_W'(rd_data_r) : '0);
  assign rem_sh   = {rem_r[REM_W-2:0], quot_r[SUM_W-1]};
  assign ref_stamp = stopped_r ? stop_r : current_r;
  assign total    = (elapsed_r >= paused_r) ? (elapsed_r - paused_r) : '0;

  assign sts.cmd        = cmd_r;
  assign sts.stopped    = stopped_r;
  assign sts.wait_hit   = wait_hit;
  assign sts.count_zero = (count_r == '0);
  assign sts.div_done   = (div_cnt_r == '0);
  assign out_rsp        = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= TPS_RESET;
      lock_r <= LOCK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TICKS_PER_SECOND: tps_r  <= cfg_data;
        REG_LOCK_INTERVAL:    lock_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.check) rd_data_r <= hist_mem[wr_ptr_r];
    if (ctl.push && push_r) hist_mem[wr_ptr_r] <= iv_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_req.command;
      ts_r  <= in_req.timestamp;
    end
    if (ctl.check) iv_r <= iv;
    if (ctl.elapsed) elapsed_r <= ref_stamp - base_r;
    if (ctl.exec) begin
      if (cmd_r == CMD_START && stopped_r) tmp_r <= ts_r - stop_r;
      else if (cmd_r == CMD_START) tmp_r <= '0;
      else tmp_r <= ts_r - last_r;
    end
    if (ctl.div_start) begin
      quot_r    <= sum_r;
      rem_r     <= '0;
      div_cnt_r <= DC_W'(SUM_W);
    end else if (ctl.div_run && div_cnt_r != '0) begin
      if (rem_sh >= REM_W'(count_r)) begin
        rem_r  <= rem_sh - REM_W'(count_r);
        quot_r <= {quot_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        quot_r <= {quot_r[SUM_W-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r - DC_W'(1);
    end
    if (ctl.out_load) begin
      out_r.average_ticks <= stopped_r ? '0 : prev_avg_r;
      out_r.frame_rate    <= rate_r;
      out_r.total_ticks   <= total;
      out_r.is_stopped    <= stopped_r;
      out_r.waiting       <= waiting_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r     <= '0;
      current_r  <= '0;
      base_r     <= '0;
      stop_r     <= '0;
      paused_r   <= '0;
      stopped_r  <= 1'b0;
      waiting_r  <= 1'b0;
      push_r     <= 1'b0;
      prev_avg_r <= '0;
      sum_r      <= '0;
      count_r    <= '0;
      wr_ptr_r   <= '0;
      frames_r   <= '0;
      rate_r     <= '0;
      wticks_r   <= '0;
    end else begin
      if (ctl.load) waiting_r <= 1'b0;
      if (ctl.exec) begin
        case (cmd_r)
          CMD_TICK: begin
            if (stopped_r) prev_avg_r <= '0;
          end
          CMD_START: begin
            if (stopped_r) begin
              last_r    <= ts_r;
              stop_r    <= '0;
              stopped_r <= 1'b0;
            end
          end
          CMD_STOP: begin
            if (!stopped_r) begin
              stop_r    <= ts_r;
              stopped_r <= 1'b1;
            end
          end
          CMD_RESET: begin
            base_r    <= ts_r;
            last_r    <= ts_r;
            current_r <= ts_r;
            stop_r    <= '0;
            paused_r  <= '0;
            stopped_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (ctl.pause) paused_r <= paused_r + tmp_r;
      if (ctl.check) begin
        if (wait_hit) begin
          waiting_r <= 1'b1;
        end else begin
          last_r    <= ts_r;
          current_r <= ts_r;
          push_r    <= (diff < tps_r);
          if (wt_sum > WT_W'(tps_r)) begin
            rate_r   <= frames_inc;
            frames_r <= '0;
            wticks_r <= '0;
          end else begin
            frames_r <= frames_inc;
            wticks_r <= wt_sum;
          end
        end
      end
      if (ctl.push && push_r) begin
        sum_r <= sum_nxt;
        if (!full) count_r <= count_r + CNT_W'(1);
        if (wr_ptr_r == PTR_W'(HISTORY_DEPTH - 1)) wr_ptr_r <= '0;
        else wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (ctl.div_start && count_r == '0) prev_avg_r <= '0;
      if (ctl.div_run && div_cnt_r == '0) prev_avg_r <= quot_r[IV_W-1:0];
    end
  end

endmodule

FILE: rtl/frame_interval_meter.sv
// Frame interval meter: a tick that updates the average passes exec, check, push, divider
// start, the bit-serial divider steps, elapsed and output. Start ticks pause after exec;
// stop, reset and stopped ticks go from exec to elapsed, waiting ticks after check and an
// empty history after divider start. One request is in work at a time and the next is taken
// the cycle after the result loads. Synchronous active-low reset clears the timer state and
// restores the default register values. Depends on fim_pkg, fim_ctrl and fim_datapath.
module frame_interval_meter #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fim_pkg::fim_in_t              in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fim_pkg::fim_out_t             out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fim_pkg::IV_W-1:0]      cfg_data
);
  import fim_pkg::*;

  fim_ctl_t ctl;
  fim_sts_t sts;

  assign cfg_ready = 1'b1;

  fim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fim_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_rsp   (out_rsp)
  );

endmodule
